// File: rtl/ali_pkg.sv
// Package for the array list block: action and status codes, the cell
// command bundle, default parameter values and stream field widths.
// Depends on nothing; used by ali_cell and array_list_insert_delete.
package ali_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed widths of the stream fields.
    localparam int ACTION_W   = 2;
    localparam int VALUE_W    = 32;
    localparam int POS_IN_W   = 5;
    localparam int STATUS_W   = 2;
    localparam int POS_OUT_W  = 4;
    localparam int COUNT_W    = 5;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_REJECT   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        logic compare_en;
        logic insert_en;
        logic delete_en;
    } t_cell_cmd;

endpackage

// File: rtl/ali_cell.sv
// One storage cell of the array list chain: holds a single element, compares
// it against the search value and shifts with its neighbors on insert/delete.
// Depends on ali_pkg.
module ali_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CMP_WIDTH  = 5,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ali_pkg::t_cell_cmd    i_cmd,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [CMP_WIDTH-1:0]  i_pos,
    input  logic [CMP_WIDTH-1:0]  i_count,
    input  logic [DATA_WIDTH-1:0] i_data_below,
    input  logic [DATA_WIDTH-1:0] i_data_above,
    input  logic                  i_found_below,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_found,
    output logic                  o_first
);
    import ali_pkg::*;

    localparam logic [CMP_WIDTH-1:0] MyIndex = CMP_WIDTH'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_match;
    logic                  w_valid;

    assign w_valid = MyIndex < i_count;
    assign o_found = i_found_below | r_match;
    assign o_first = r_match & ~i_found_below;
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        if (i_cmd.insert_en) begin
            if (MyIndex > i_pos) begin
                n_data = i_data_below;
            end else if (MyIndex == i_pos) begin
                n_data = i_value;
            end
        end else if (i_cmd.delete_en && o_found) begin
            // A match at or below this cell: take the element from above.
            n_data = i_data_above;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_cmd.compare_en) begin
            r_match <= w_valid && (r_data == i_value);
        end
    end

endmodule

// File: rtl/array_list_insert_delete.sv
// Array list top level: sequencer, stream ports and the chain of ali_cell
// storage cells that hold the ordered list.
// Depends on ali_pkg and ali_cell.
//
//  Channel   Direction  Ports                           Word contents
//  -------   ---------  ------------------------------  -------------------------------
//  command   in         i_s_tvalid/o_s_tready/i_s_tdata action, item_value, position_in
//  result    out        o_m_tvalid/i_m_tready/o_m_tdata status, position_out, element_count
//
// Each command word is accepted in S_IDLE; in S_MATCH all cells compare their
// element against the value in parallel, and in S_EXEC the cells shift together
// and the result word is loaded. The compare register in each cell and the
// ripple of the match flag up the cell chain are why the compare has its own
// state. A new word is accepted only when the result register is empty or is
// being drained in the same cycle, so a stalled result holds off the next
// command. Reset is synchronous and active low; it empties the list and the
// result register, while the element contents are left as they are.
module array_list_insert_delete #(
    parameter int CAPACITY   = ali_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = ali_pkg::DEF_DATA_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command stream.
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // Fields from bit 0: action[1:0], item_value[33:2], position_in[38:34],
    // bit 39 zero fill.
    input  logic [ali_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // Result stream.
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // Fields from bit 0: status[1:0], position_out[5:2], element_count[10:6],
    // bits 15:11 zero fill.
    output logic [ali_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import ali_pkg::*;

    // Count width holds the value CAPACITY itself; comparisons with the
    // 5-bit insert position are done at the wider of the two widths.
    localparam int CntW  = $clog2(CAPACITY + 1);
    localparam int CmpW  = (CntW > POS_IN_W) ? CntW : POS_IN_W;
    localparam int IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ValW  = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state                r_state;
    t_state                n_state;

    // Latched command.
    t_action               r_action;
    logic [DATA_WIDTH-1:0] r_value;
    logic [POS_IN_W-1:0]   r_pos;

    // Number of elements held.
    logic [CntW-1:0]       r_count;
    logic [CntW-1:0]       n_count;

    // Result register.
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [POS_OUT_W-1:0]  r_out_pos;
    logic [COUNT_W-1:0]    r_out_count;

    // Unpacked input word.
    t_action               w_in_action;
    logic [VALUE_W-1:0]    w_in_value;
    logic [POS_IN_W-1:0]   w_in_pos;
    logic                  w_in_accept;
    logic                  w_out_take;

    // Execute-phase decode.
    logic [CmpW-1:0]       w_cnt;
    logic [CmpW-1:0]       w_ins_pos;
    logic [CmpW-1:0]       w_new_cnt;
    logic                  w_full;
    logic                  w_is_ins;
    logic                  w_ins_ok;
    logic                  w_del;
    logic                  w_del_ok;
    t_status               w_status;
    logic [CmpW-1:0]       w_res_pos;
    logic [IdxW-1:0]       w_first_idx;

    // Cell chain wiring.
    t_cell_cmd             w_cmd;
    logic [DATA_WIDTH-1:0] w_cell_data [CAPACITY];
    logic [CAPACITY:0]     w_found;
    logic [CAPACITY-1:0]   w_first;

    assign w_in_action = t_action'(i_s_tdata[ACTION_W-1:0]);
    assign w_in_value  = i_s_tdata[ACTION_W +: VALUE_W];
    assign w_in_pos    = i_s_tdata[ACTION_W + VALUE_W +: POS_IN_W];

    // A command is taken only when the result register will be free by the
    // time this command's result is loaded.
    assign o_s_tready  = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_in_accept = i_s_tvalid && o_s_tready;
    assign w_out_take  = r_out_valid && i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W - STATUS_W - POS_OUT_W - COUNT_W)'(0),
                         r_out_count, r_out_pos, r_out_status};

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command latch; the value is cut or zero-extended to the element width.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_action <= w_in_action;
            r_value  <= DATA_WIDTH'(w_in_value[ValW-1:0]);
            r_pos    <= w_in_pos;
        end
    end

    // Decode of the latched command against the current list.
    assign w_cnt     = CmpW'(r_count);
    assign w_full    = (r_count == CntW'(CAPACITY));
    assign w_is_ins  = (r_action == ACT_INSERT) || (r_action == ACT_APPEND);
    assign w_ins_pos = (r_action == ACT_APPEND) ? w_cnt : CmpW'(r_pos);
    assign w_ins_ok  = w_is_ins && !w_full && (w_ins_pos <= w_cnt);
    assign w_del     = (r_action == ACT_DELETE) && (r_count != '0);
    assign w_del_ok  = w_del && w_found[CAPACITY];

    // Binary index of the lowest matching cell; at most one cell is first.
    always_comb begin
        w_first_idx = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_first[k]) begin
                w_first_idx = w_first_idx | IdxW'(k);
            end
        end
    end

    always_comb begin
        w_status  = ST_REJECT;
        w_res_pos = '0;
        w_new_cnt = w_cnt;
        unique case (r_action)
            ACT_INSERT, ACT_APPEND: begin
                if (w_ins_ok) begin
                    w_status  = ST_DONE;
                    w_res_pos = w_ins_pos;
                    w_new_cnt = w_cnt + CmpW'(1);
                end
            end
            ACT_DELETE: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_del_ok) begin
                    w_status  = ST_DONE;
                    w_res_pos = CmpW'(w_first_idx);
                    w_new_cnt = w_cnt - CmpW'(1);
                end else begin
                    w_status = ST_NOTFOUND;
                end
            end
            ACT_NONE: w_status = ST_REJECT;
            default:  w_status = ST_REJECT;
        endcase
    end

    assign n_count = (r_state == S_EXEC) ? CntW'(w_new_cnt) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Result register: loaded at the end of execute, drained by the sink.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EXEC) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_out_status <= w_status;
            r_out_pos    <= w_res_pos[POS_OUT_W-1:0];
            r_out_count  <= COUNT_W'(w_new_cnt);
        end
    end

    // Commands broadcast to the cells. The compare runs in its own state, S_MATCH, so
    // that the wide equality sits in front of a register in every cell.
    assign w_cmd.compare_en = (r_state == S_MATCH);
    assign w_cmd.insert_en  = (r_state == S_EXEC) && w_ins_ok;
    assign w_cmd.delete_en  = (r_state == S_EXEC) && w_del;

    // The match flag ripples from cell 0 upward; the first matching cell and each
    // cell above it take their upper neighbor's element on a delete.
    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_below;
        logic [DATA_WIDTH-1:0] w_above;

        if (g == 0) begin : g_bottom
            assign w_below = '0;
        end else begin : g_mid_lo
            assign w_below = w_cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_top
            assign w_above = '0;
        end else begin : g_mid_hi
            assign w_above = w_cell_data[g+1];
        end

        ali_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CMP_WIDTH  (CmpW),
            .INDEX      (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_value       (r_value),
            .i_pos         (w_ins_pos),
            .i_count       (w_cnt),
            .i_data_below  (w_below),
            .i_data_above  (w_above),
            .i_found_below (w_found[g]),
            .o_data        (w_cell_data[g]),
            .o_found       (w_found[g+1]),
            .o_first       (w_first[g])
        );
    end

`ifndef SYNTHESIS
    // The list never holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(CAPACITY))
        else $error("element count exceeds capacity");

    // Only one cell can ever claim to be the lowest match.
    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one first-match cell");

    // A rejected or failed action leaves the count untouched.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && w_status != ST_DONE) |=> $stable(r_count))
        else $error("count changed on an unsuccessful action");

    // A command is never taken while an older result would be left stranded.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && r_out_valid) |-> i_m_tready)
        else $error("command accepted over a pending result");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for array_list_insert_delete: directed and random command words,
// checked against a predictor of the ordered list kept in a scoreboard class.
// Depends on ali_pkg and the RTL of array_list_insert_delete.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ali_pkg::*;

    localparam int LIST_CAP       = ali_pkg::DEF_CAPACITY;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 475;

    // Expected contents of the list and of every result word still to come.
    class list_checker;
        typedef struct packed {
            t_status    status;
            logic [3:0] pos;
            logic [4:0] count;
        } t_list_result;

        logic [31:0]  elems [LIST_CAP];
        int           fill;
        t_list_result awaited_results[$];
        int unsigned  failures;

        function new();
            fill = 0;
            failures = 0;
        endfunction

        function int pending_count();
            return awaited_results.size();
        endfunction

        // Applies one accepted command word to the list and queues its result.
        function void apply_command(t_action act, logic [31:0] value, logic [4:0] where);
            t_list_result r;
            int hit;
            r = '{ST_REJECT, 4'd0, 5'd0};
            hit = -1;
            case (act)
                ACT_INSERT, ACT_APPEND: begin
                    if (act == ACT_APPEND) where = 5'(fill);
                    if (where <= fill && fill < LIST_CAP) begin
                        for (int k = fill; k > where; k--) elems[k] = elems[k-1];
                        elems[where] = value;
                        fill++;
                        r.status = ST_DONE;
                        r.pos = where[3:0];
                    end
                end
                ACT_DELETE: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        for (int i = 0; i < fill && hit < 0; i++)
                            if (elems[i] == value) hit = i;
                        if (hit < 0) begin
                            r.status = ST_NOTFOUND;
                        end else begin
                            for (int k = hit; k + 1 < fill; k++) elems[k] = elems[k+1];
                            fill--;
                            r.status = ST_DONE;
                            r.pos = 4'(hit);
                        end
                    end
                end
                default: ;
            endcase
            r.count = 5'(fill);
            awaited_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] word);
            t_list_result exp;
            if (awaited_results.size() == 0) begin
                $error("result word %h arrived with no command waiting", word);
                failures++;
                return;
            end
            exp = awaited_results.pop_front();
            if (word[1:0] !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, word[1:0]);
                failures++;
            end
            if (word[5:2] !== exp.pos) begin
                $error("position_out: expected %0d, got %0d", exp.pos, word[5:2]);
                failures++;
            end
            if (word[10:6] !== exp.count) begin
                $error("element_count: expected %0d, got %0d", exp.count, word[10:6]);
                failures++;
            end
            if (word[15:11] !== 5'd0) begin
                $error("zero fill: expected 0, got %0d", word[15:11]);
                failures++;
            end
        endfunction

        function void check_leftover();
            if (awaited_results.size() != 0) begin
                $error("%0d result words never arrived", awaited_results.size());
                failures++;
            end
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // Fields from bit 0: action[1:0], item_value[33:2], position_in[38:34], bit 39 zero.
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // Fields from bit 0: status[1:0], position_out[5:2], element_count[10:6], rest zero.
    logic [OUT_DATA_W-1:0] o_m_tdata;

    list_checker ordered_list = new();
    event        cmd_taken;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;

    array_list_insert_delete dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    // The receiver drops tready at random while the current phase asks for stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Both channels are sampled here. A result word is checked before the command
    // word taken at the same edge is applied, so the new command can never be
    // matched against that result. The driver is released only after the list
    // has been updated, so the stimulus always sees the settled list.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) ordered_list.check_result(o_m_tdata);
            if (i_s_tvalid && o_s_tready) begin
                ordered_list.apply_command(t_action'(i_s_tdata[1:0]), i_s_tdata[33:2],
                                           i_s_tdata[38:34]);
                -> cmd_taken;
            end
        end
        // The watchdog counts cycles in which neither channel moves a word.
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one command word, with random idle cycles ahead of it, and returns
    // once the block has taken it and the list has been updated.
    task automatic send_command(t_action act, logic [31:0] value, logic [4:0] where);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, where, value, act};
        @(cmd_taken);
    endtask

    // Holds the sender off until every result word still owed has come back.
    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (ordered_list.pending_count() != 0);
    endtask

    // Small values make duplicates common, so delete has to find the first match.
    function automatic logic [31:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 35) return 32'($urandom_range(7));
        if (roll < 40) return 32'd0;
        if (roll < 45) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // One random word. While filling, inserts outweigh deletes, and the other way
    // round while draining, so the list swings between empty and full. Most
    // deletes name a value that is held; a few words are out of range or unused.
    task automatic random_command(bit filling);
        int unsigned roll;
        int          fill;
        logic [31:0] value;
        logic [4:0]  where;
        t_action     act;
        fill  = ordered_list.fill;
        roll  = $urandom_range(99);
        value = pick_value();
        where = 5'($urandom);
        if (roll < 3) begin
            act = ACT_NONE;
        end else if (roll < 7) begin
            act   = ACT_INSERT;
            where = 5'($urandom_range(31, fill + 1));
        end else if (roll < (filling ? 70 : 35)) begin
            if ($urandom_range(2) == 0) begin
                act = ACT_APPEND;
            end else begin
                act   = ACT_INSERT;
                where = 5'($urandom_range(fill));
            end
        end else begin
            act = ACT_DELETE;
            if (fill > 0 && $urandom_range(99) < 75)
                value = ordered_list.elems[$urandom_range(fill - 1)];
        end
        send_command(act, value, where);
    endtask

    initial begin
        int unsigned idle_mix [4][2];
        int unsigned tide_left;
        bit          filling;

        idle_mix = '{'{0, 0}, '{75, 0}, '{0, 75}, '{6, 6}};
        filling  = 1'b1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: the empty list, the unused action code, an insert past
        // the count, inserts at both ends and in the middle, a delete with no
        // match and one in the middle, then a full list with duplicate values.
        send_command(ACT_DELETE, 32'd5, 5'd0);
        send_command(ACT_NONE, 32'hFFFF_FFFF, 5'd31);
        send_command(ACT_INSERT, 32'd1, 5'd1);
        send_command(ACT_INSERT, 32'd0, 5'd0);
        send_command(ACT_APPEND, 32'hFFFF_FFFF, 5'd31);
        send_command(ACT_INSERT, 32'h0000_1234, 5'd1);
        send_command(ACT_INSERT, 32'd7, 5'd3);
        send_command(ACT_DELETE, 32'd99, 5'd0);
        send_command(ACT_DELETE, 32'h0000_1234, 5'd16);
        send_command(ACT_INSERT, 32'd3, 5'd17);
        send_command(ACT_INSERT, 32'd3, 5'd16);
        while (ordered_list.fill < LIST_CAP)
            send_command(ACT_APPEND,
                         (ordered_list.fill % 3 == 0) ? 32'd7 : 32'(ordered_list.fill),
                         5'($urandom));
        send_command(ACT_APPEND, 32'd8, 5'd0);
        send_command(ACT_INSERT, 32'd8, 5'd0);
        send_command(ACT_INSERT, 32'd8, 5'd16);
        send_command(ACT_DELETE, 32'd7, 5'd0);
        send_command(ACT_DELETE, 32'hFFFF_FFFF, 5'd0);

        // Random part, in phases of different idling. Each phase starts from a
        // drained pipeline, which also exercises a sender that waits for results.
        for (int ph = 0; ph < 4; ph++) begin
            hold_until_drained();
            send_idle_pct  = idle_mix[ph][0];
            recv_stall_pct = idle_mix[ph][1];
            tide_left      = $urandom_range(60, 20);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (tide_left == 0) begin
                    filling   = !filling;
                    tide_left = $urandom_range(60, 20);
                end
                tide_left--;
                random_command(filling);
            end
        end

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        ordered_list.check_leftover();
        if (ordered_list.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/ali_pkg.sv
rtl/ali_cell.sv
rtl/array_list_insert_delete.sv
tb/tb.sv
